>>> rtl/exp_taylor_series_assert.svh
// Assertion macros shared by the exponential series block.
`ifndef EXP_TAYLOR_SERIES_ASSERT_SVH
`define EXP_TAYLOR_SERIES_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ETS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ETS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ets_pkg.sv
// Package with types, constants and the reciprocal table of the exponential series block.
package ets_pkg;

	localparam int unsigned MAX_TERMS_DEF = 20;
	localparam int unsigned ARG_W = 32;
	localparam int unsigned TERM_W = 64;
	localparam int unsigned SUM_W = 48;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned RCP_DEPTH = 20;

	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// Reciprocal 1/k in Q0.32, rounded to nearest. Entries 0 and 1 are unused.
	localparam logic [31:0] RCP_TABLE [RCP_DEPTH] = '{
		32'd0,
		32'd0,
		32'((ONE_Q32 + 64'd1) / 64'd2),
		32'((ONE_Q32 + 64'd1) / 64'd3),
		32'((ONE_Q32 + 64'd2) / 64'd4),
		32'((ONE_Q32 + 64'd2) / 64'd5),
		32'((ONE_Q32 + 64'd3) / 64'd6),
		32'((ONE_Q32 + 64'd3) / 64'd7),
		32'((ONE_Q32 + 64'd4) / 64'd8),
		32'((ONE_Q32 + 64'd4) / 64'd9),
		32'((ONE_Q32 + 64'd5) / 64'd10),
		32'((ONE_Q32 + 64'd5) / 64'd11),
		32'((ONE_Q32 + 64'd6) / 64'd12),
		32'((ONE_Q32 + 64'd6) / 64'd13),
		32'((ONE_Q32 + 64'd7) / 64'd14),
		32'((ONE_Q32 + 64'd7) / 64'd15),
		32'((ONE_Q32 + 64'd8) / 64'd16),
		32'((ONE_Q32 + 64'd8) / 64'd17),
		32'((ONE_Q32 + 64'd9) / 64'd18),
		32'((ONE_Q32 + 64'd9) / 64'd19)
	};

	// Register indexes of the configuration port.
	typedef enum logic [0:0] {
		REG_TERM_COUNT = 1'b0,
		REG_UNUSED     = 1'b1
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             accumulate;
		logic             mul_lo;
		logic             mul_hi;
		logic             combine;
		logic             use_rcp;
		logic             publish;
		logic [CNT_W-1:0] k;
	} ets_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_ovf;
	} ets_stat_t;

	function automatic logic [31:0] rcp_lookup(input logic [CNT_W-1:0] k);
		logic [31:0] r;
		r = '0;
		if (k < CNT_W'(RCP_DEPTH)) begin
			r = RCP_TABLE[k];
		end
		return r;
	endfunction

endpackage

>>> rtl/ets_if.sv
// Valid-ready channel interfaces for the argument and the result of the series block.
interface ets_arg_if
	import ets_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [ARG_W-1:0] argument;

	modport source (output valid, output argument, input ready);
	modport sink (input valid, input argument, output ready);
endinterface

interface ets_res_if
	import ets_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] exp_value;
	logic             overflow;

	modport source (output valid, output exp_value, output overflow, input ready);
	modport sink (input valid, input exp_value, input overflow, output ready);
endinterface

>>> rtl/ets_ctrl.sv
// Controller state machine that sequences the series terms.
`include "exp_taylor_series_assert.svh"

module ets_ctrl
	import ets_pkg::*;
#(
	parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] term_count,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ets_cmd_t         cmd,
	input  ets_stat_t        stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MLO,
		ST_MHI,
		ST_COMB,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;
	logic             rcp_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] n_cap;
	logic             in_fire;
	logic             publish;

	assign n_cap = (term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign publish = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.accumulate = (state_q == ST_ACC);
		cmd.mul_lo = (state_q == ST_MLO);
		cmd.mul_hi = (state_q == ST_MHI);
		cmd.combine = (state_q == ST_COMB);
		cmd.use_rcp = rcp_q;
		cmd.publish = publish;
		cmd.k = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			k_q <= '0;
			rcp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						n_q <= n_cap;
						k_q <= '0;
						rcp_q <= 1'b0;
						state_q <= (n_cap == '0) ? ST_DONE : ST_ACC;
					end
				end
				ST_ACC: begin
					if (stat.acc_ovf || (k_q + CNT_W'(1) == n_q)) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + CNT_W'(1);
						rcp_q <= 1'b0;
						state_q <= ST_MLO;
					end
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					state_q <= ST_COMB;
				end
				ST_COMB: begin
					if (!rcp_q && (k_q >= CNT_W'(2))) begin
						rcp_q <= 1'b1;
						state_q <= ST_MLO;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_DONE: begin
					if (publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ETS_ASSERT(a_accept_starts, in_fire |=> (state_q == ST_ACC) || (state_q == ST_DONE), "accepted item did not start")
	`ETS_NEVER(a_k_range, k_q >= CNT_W'(MAX_TERMS), "term index beyond the cap")
	`ETS_ASSERT(a_valid_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result shown without finishing")

endmodule

>>> rtl/ets_dp.sv
// Datapath with the shared multiplier, term register and saturating accumulator.
module ets_dp
	import ets_pkg::*;
(
	input  logic             clk,
	input  logic [ARG_W-1:0] argument,
	input  ets_cmd_t         cmd,
	output ets_stat_t        stat,
	output logic [SUM_W-1:0] exp_value,
	output logic             overflow
);

	logic [ARG_W-1:0]  x_q;
	logic [TERM_W-1:0] term_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic [63:0]       plo_q;
	logic [63:0]       phi_q;
	logic [SUM_W-1:0]  exp_q;
	logic              ovf_out_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [95:0]       wide;
	logic [TERM_W-1:0] next_term;
	logic [SUM_W:0]    sum_ext;
	logic              acc_ovf;

	// One 32 by 32 multiplier, fed with the low or high half of the term.
	assign mul_a = cmd.mul_hi ? term_q[63:32] : term_q[31:0];
	assign mul_b = cmd.use_rcp ? rcp_lookup(cmd.k) : x_q;
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// Join the partial products and scale: by 2^28 for x, by 2^32 for 1/k.
	assign wide = {phi_q, 32'b0} + {32'b0, plo_q};
	always_comb begin
		if (cmd.use_rcp) begin
			next_term = wide[95:32];
		end else if (wide[95:92] != '0) begin
			next_term = '1;
		end else begin
			next_term = wide[91:28];
		end
	end

	assign sum_ext = {1'b0, sum_q} + {1'b0, term_q[SUM_W-1:0]};
	assign acc_ovf = (term_q[TERM_W-1:SUM_W] != '0) || sum_ext[SUM_W];
	assign stat.acc_ovf = acc_ovf;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= argument;
			term_q <= ONE_Q32;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.mul_lo) begin
				plo_q <= mul_p;
			end
			if (cmd.mul_hi) begin
				phi_q <= mul_p;
			end
			if (cmd.combine) begin
				term_q <= next_term;
			end
			if (cmd.accumulate) begin
				if (acc_ovf) begin
					sum_q <= SUM_MAX;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
			end
		end
		if (cmd.publish) begin
			exp_q <= sum_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign exp_value = exp_q;
	assign overflow = ovf_out_q;

endmodule

>>> rtl/exp_taylor_series.sv
// Top level of the truncated Taylor series exponential block.
//
// Channel    Kind          Direction  Carries
// operand    valid/ready   in         argument, unsigned Q4.28
// result     valid/ready   out        exp_value (unsigned Q16.32), overflow
// apb        APB-style     in/out     term_count at byte address 0
//
// Because of the single 32 by 32 multiplier, term 1 needs one pass (times
// x) and every later term two (times x, then times 1/k), each pass two
// partial products and a combine, and an accumulate step adds each term
// into the sum. The series stops early once the sum saturates. A result
// that finds the output register still occupied waits in the controller
// until the earlier result has had its transfer.
// Reset clears the controller and sets term_count to 20; no clearing pass.
// A new argument is taken as soon as the controller is idle, while a finished
// result may still wait in the output register for its transfer.
module exp_taylor_series
	import ets_pkg::*;
#(
	parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ets_arg_if.sink     operand,
	ets_res_if.source   result
);

	logic [CNT_W-1:0] term_count_q;
	reg_idx_t         reg_idx;
	logic             cfg_write;
	ets_cmd_t         cmd;
	ets_stat_t        stat;

	// Registers sit on 32-bit words; bit 2 picks the word, lower bits are ignored.
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= CNT_W'(MAX_TERMS_DEF);
		end else if (cfg_write && (reg_idx == REG_TERM_COUNT)) begin
			term_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TERM_COUNT: prdata = {{(32-CNT_W){1'b0}}, term_count_q};
			default:        prdata = '0;
		endcase
	end

	// The controller walks through the terms; the datapath does the arithmetic.
	ets_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_count (term_count_q),
		.in_valid   (operand.valid),
		.in_ready   (operand.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	ets_dp u_dp (
		.clk        (clk),
		.argument   (operand.argument),
		.cmd        (cmd),
		.stat       (stat),
		.exp_value  (result.exp_value),
		.overflow   (result.overflow)
	);

endmodule
